// ----- hw/rtl/ugr_pkg.sv -----
// shared widths, status codes and controller/datapath interface structs
package ugr_pkg;

  localparam int X_W       = 32;
  localparam int Y_W       = 32;
  localparam int GRID_W    = 33;
  localparam int STEP_W    = 20;
  localparam int STATUS_W  = 2;
  localparam int DIV_W     = 32;

  localparam int MAX_RUN_DEF      = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RUN     = 2'd2;

  typedef struct packed {
    logic                lat_in;
    logic                div_start;
    logic                div_ceil;
    logic                set_first;
    logic                mul;
    logic                emit_point;
    logic                emit_halt;
    logic [STATUS_W-1:0] halt_code;
    logic                commit_prev;
    logic                finish;
  } ugr_cmd_t;

  typedef struct packed {
    logic stopped;
    logic have_prev;
    logic x_lt_prev;
    logic grid_le_x;
    logic x_eq_prev;
    logic run_long;
    logic last_point;
    logic div_done;
    logic out_free;
  } ugr_sts_t;

endpackage

// ----- hw/rtl/ugr_divider.sv -----
// iterative restoring divider, one quotient bit per cycle, quotient must fit DIV_W bits
module ugr_divider import ugr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2*DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0]   divisor,
  output logic               done,
  output logic [DIV_W-1:0]   quotient,
  output logic [DIV_W-1:0]   remainder
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = dividend[2*DIV_W-1:DIV_W];
      quo_nxt = dividend[DIV_W-1:0];
      dsr_nxt = divisor;
      cnt_nxt = CNT_W'(DIV_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_nxt  = {quo_r[DIV_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- hw/rtl/ugr_ctrl.sv -----
// sequencing state machine: decide, multiply, divide, emit or halt, finish
module ugr_ctrl import ugr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ugr_sts_t sts,
  output ugr_cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECIDE  = 4'd1;
  localparam logic [3:0] S_CEIL    = 4'd2;
  localparam logic [3:0] S_MUL     = 4'd3;
  localparam logic [3:0] S_DIVGO   = 4'd4;
  localparam logic [3:0] S_DIVWAIT = 4'd5;
  localparam logic [3:0] S_EMIT    = 4'd6;
  localparam logic [3:0] S_HALT    = 4'd7;
  localparam logic [3:0] S_FINISH  = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] halt_code_r, halt_code_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    halt_code_nxt = halt_code_r;
    cmd           = '0;
    cmd.halt_code = halt_code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.lat_in = 1'b1;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (sts.stopped) begin
          state_nxt = S_FINISH;
        end else if (!sts.have_prev) begin
          cmd.div_start = 1'b1;
          cmd.div_ceil  = 1'b1;
          state_nxt     = S_CEIL;
        end else if (sts.x_lt_prev) begin
          halt_code_nxt = ST_INVALID;
          state_nxt     = S_HALT;
        end else if (sts.grid_le_x) begin
          priority if (sts.x_eq_prev) begin
            halt_code_nxt = ST_INVALID;
            state_nxt     = S_HALT;
          end else if (sts.run_long) begin
            halt_code_nxt = ST_RUN;
            state_nxt     = S_HALT;
          end else begin
            state_nxt = S_MUL;
          end
        end else begin
          // no grid point in this interval
          cmd.commit_prev = 1'b1;
          state_nxt       = S_FINISH;
        end
      end
      S_CEIL: begin
        if (sts.div_done) begin
          cmd.set_first = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (sts.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_point = 1'b1;
          if (sts.last_point) begin
            cmd.commit_prev = 1'b1;
            state_nxt       = S_FINISH;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_HALT: begin
        if (sts.out_free) begin
          cmd.emit_halt = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      halt_code_r <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      halt_code_r <= halt_code_nxt;
    end
  end

endmodule

// ----- hw/rtl/ugr_datapath.sv -----
// series state, interpolation arithmetic, shared divider and output register
module ugr_datapath import ugr_pkg::*; #(
  parameter int MAX_RUN      = MAX_RUN_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [STEP_W-1:0]          cfg_wr_data,
  input  logic [X_W-1:0]             in_sample_x,
  input  logic signed [Y_W-1:0]      in_sample_y,
  input  logic                       in_last_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [X_W-1:0]             out_grid_x,
  output logic signed [Y_W-1:0]      out_value,
  output logic                       out_last_of_run,
  output logic [STATUS_W-1:0]        out_status,
  input  ugr_cmd_t                   cmd,
  output ugr_sts_t                   sts
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int RUN_W  = $clog2(MAX_RUN + 1);
  localparam int SPAN_W = STEP_W + RUN_W;
  localparam int PROD_W = SW + X_W;

  // configuration
  logic [STEP_W-1:0] grid_step_r, grid_step_nxt;
  logic [STEP_W-1:0] step;
  logic [SPAN_W-1:0] span_r;

  // latched input item
  logic [X_W-1:0]       cur_x_r;
  logic signed [SW-1:0] cur_y_r;
  logic                 cur_last_r;

  // series state
  logic [X_W-1:0]       prev_x_r, prev_x_nxt;
  logic signed [SW-1:0] prev_y_r, prev_y_nxt;
  logic                 have_prev_r, have_prev_nxt;
  logic [GRID_W-1:0]    next_grid_r, next_grid_nxt;
  logic                 stopped_r, stopped_nxt;

  // interpolation
  logic signed [SW:0]   dy;
  logic [SW:0]          dy_abs;
  logic [SW-1:0]        mag_r;
  logic                 dy_neg_r;
  logic [GRID_W-1:0]    a_full;
  logic [PROD_W-1:0]    product_r;
  logic [GRID_W-1:0]    ng_step;
  logic [GRID_W-1:0]    run_diff;
  logic [SW-1:0]        quo_sw;
  logic signed [SW:0]   vsum;
  logic signed [SW-1:0] v_sw;

  // divider
  logic [2*DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0]   div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;
  logic [DIV_W-1:0]   div_rem;
  logic [STEP_W-1:0]  ceil_adj;
  logic [GRID_W-1:0]  ceil_grid;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [X_W-1:0]       out_grid_x_r;
  logic signed [Y_W-1:0] out_value_r;
  logic                 out_last_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic                 out_free;

  assign step = (grid_step_r == '0) ? STEP_W'(1) : grid_step_r;

  always_comb begin
    grid_step_nxt = cfg_wr_en ? cfg_wr_data : grid_step_r;
  end

  assign dy     = (SW+1)'(cur_y_r) - (SW+1)'(prev_y_r);
  assign dy_abs = dy[SW] ? (SW+1)'(-dy) : (SW+1)'(dy);

  assign a_full   = next_grid_r - GRID_W'(prev_x_r);
  assign ng_step  = next_grid_r + GRID_W'(step);
  assign run_diff = GRID_W'(cur_x_r) - next_grid_r;

  // quotient never exceeds the magnitude of dy
  assign quo_sw = div_quo[SW-1:0];
  assign vsum   = dy_neg_r ? (SW+1)'(prev_y_r) - $signed({1'b0, quo_sw})
                           : (SW+1)'(prev_y_r) + $signed({1'b0, quo_sw});
  assign v_sw   = vsum[SW-1:0];

  assign div_dividend = cmd.div_ceil ? (2*DIV_W)'(cur_x_r) : (2*DIV_W)'(product_r);
  assign div_divisor  = cmd.div_ceil ? DIV_W'(step) : DIV_W'(cur_x_r - prev_x_r);

  ugr_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // round the first sample position up to the grid
  assign ceil_adj  = (div_rem[STEP_W-1:0] != '0) ? step - div_rem[STEP_W-1:0] : '0;
  assign ceil_grid = GRID_W'(cur_x_r) + GRID_W'(ceil_adj);

  always_comb begin
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    have_prev_nxt = have_prev_r;
    next_grid_nxt = next_grid_r;
    stopped_nxt   = stopped_r;
    if (cmd.set_first) begin
      prev_x_nxt    = cur_x_r;
      prev_y_nxt    = cur_y_r;
      have_prev_nxt = 1'b1;
      next_grid_nxt = ceil_grid;
    end
    if (cmd.commit_prev) begin
      prev_x_nxt = cur_x_r;
      prev_y_nxt = cur_y_r;
    end
    if (cmd.emit_point) next_grid_nxt = ng_step;
    if (cmd.emit_halt) stopped_nxt = 1'b1;
    if (cmd.finish && cur_last_r) begin
      prev_x_nxt    = '0;
      prev_y_nxt    = '0;
      have_prev_nxt = 1'b0;
      next_grid_nxt = '0;
      stopped_nxt   = 1'b0;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_point || cmd.emit_halt) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_step_r <= STEP_W'(1);
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      next_grid_r <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      grid_step_r <= grid_step_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      have_prev_r <= have_prev_nxt;
      next_grid_r <= next_grid_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span_r   <= SPAN_W'(step) * SPAN_W'(MAX_RUN);
    mag_r    <= dy_abs[SW-1:0];
    dy_neg_r <= dy[SW];
    if (cmd.lat_in) begin
      cur_x_r    <= in_sample_x;
      cur_y_r    <= in_sample_y[SW-1:0];
      cur_last_r <= in_last_sample;
    end
    if (cmd.mul) product_r <= PROD_W'(mag_r) * PROD_W'(a_full[X_W-1:0]);
    if (cmd.emit_point) begin
      out_grid_x_r <= next_grid_r[X_W-1:0];
      out_value_r  <= Y_W'(v_sw);
      out_last_r   <= (ng_step > GRID_W'(cur_x_r));
      out_status_r <= ST_OK;
    end else if (cmd.emit_halt) begin
      out_grid_x_r <= next_grid_r[X_W-1:0];
      out_value_r  <= '0;
      out_last_r   <= 1'b1;
      out_status_r <= cmd.halt_code;
    end
  end

  always_comb begin
    sts            = '0;
    sts.stopped    = stopped_r;
    sts.have_prev  = have_prev_r;
    sts.x_lt_prev  = (cur_x_r < prev_x_r);
    sts.grid_le_x  = (next_grid_r <= GRID_W'(cur_x_r));
    sts.x_eq_prev  = (cur_x_r == prev_x_r);
    // more than MAX_RUN points when the gap reaches MAX_RUN steps
    sts.run_long   = (run_diff >= GRID_W'(span_r));
    sts.last_point = (ng_step > GRID_W'(cur_x_r));
    sts.div_done   = div_done;
    sts.out_free   = out_free;
  end

  assign out_valid       = out_valid_r;
  assign out_grid_x      = out_grid_x_r;
  assign out_value       = out_value_r;
  assign out_last_of_run = out_last_r;
  assign out_status      = out_status_r;

endmodule

// ----- hw/rtl/uniform_grid_linear_resampler.sv -----
// A first sample runs a ceiling division on the shared divider to find its first grid point.
// Each grid point takes one multiply, an iterative division and one output write.
// An item with no grid point or a stopped series goes to finish; a status stop emits first.
// The shared iterative divider paces the block; in_stall holds off items until one is done.
// Reset (synchronous, active low) clears the series state and sets grid_step to 1.
module uniform_grid_linear_resampler import ugr_pkg::*; #(
  parameter int MAX_RUN      = MAX_RUN_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [STEP_W-1:0]     cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [X_W-1:0]        in_sample_x,
  input  logic signed [Y_W-1:0] in_sample_y,
  input  logic                  in_last_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [X_W-1:0]        out_grid_x,
  output logic signed [Y_W-1:0] out_value,
  output logic                  out_last_of_run,
  output logic [STATUS_W-1:0]   out_status
);

  ugr_cmd_t cmd;
  ugr_sts_t sts;

  ugr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ugr_datapath #(
    .MAX_RUN      (MAX_RUN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_sample_x     (in_sample_x),
    .in_sample_y     (in_sample_y),
    .in_last_sample  (in_last_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_grid_x      (out_grid_x),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run),
    .out_status      (out_status),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
